>>> hdl/wdt_pkg.sv
package wdt_pkg;

  localparam int VocabSize    = 256;
  localparam int MaxTokens    = 12;
  localparam int MaxWordChars = 31;
  localparam int EntryStride  = 32;

  localparam int EntryW = $clog2(VocabSize);
  localparam int CharAw = EntryW + $clog2(EntryStride);
  localparam int PosW   = $clog2(EntryStride);
  localparam int LenW   = 5;
  localparam int CountW = 9;
  localparam int SlotW  = 4;
  localparam int IdW    = 16;
  localparam int CfgW   = 16;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [IdW-1:0]    UnknownId = IdW'(1);
  localparam logic [IdW-1:0]    PadToken  = '0;
  localparam logic [SlotW-1:0]  MaxTok    = SlotW'(MaxTokens);
  localparam logic [LenW-1:0]   MaxChars  = LenW'(MaxWordChars);
  localparam logic [CountW-1:0] VocabLim  = CountW'(VocabSize);

  typedef enum logic [1:0] {
    OpLoadChar  = 2'd0,
    OpLoadEntry = 2'd1,
    OpTextByte  = 2'd2,
    OpEndText   = 2'd3
  } op_e;

  typedef enum logic {
    CfgVocabCount = 1'b0,
    CfgNumTokenId = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [7:0]       entry_index;
    logic [4:0]       char_pos;
    logic [7:0]       char_value;
    logic [15:0]      entry_id;
    logic [4:0]       entry_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] token_id;
    logic [3:0]  slot;
    logic [3:0]  real_count;
    logic        last_flag;
  } out_item_t;

  // Work handed from the front end to the back end.
  typedef struct packed {
    logic             lookup;    // word needs a dictionary search
    logic             pads;      // emit padding after this job
    logic             has_word;  // a word token is emitted
    logic [IdW-1:0]   id;        // id if no search
    logic [LenW-1:0]  len;
    logic [SlotW-1:0] slot;      // slot of first result
    logic             last_word; // the word fills the last slot
  } job_t;

endpackage

>>> hdl/wdt_if.sv
interface wdt_in_if;
  logic               valid;
  logic               ready;
  wdt_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wdt_out_if;
  logic               valid;
  logic               ready;
  wdt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/wdt_front.sv
module wdt_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wdt_pkg::in_item_t           in_data_i,
  input  logic [wdt_pkg::IdW-1:0]     num_id_i,
  input  logic                        back_busy_i,
  output logic                        job_valid_o,
  output wdt_pkg::job_t               job_o,
  input  logic                        job_ready_i,
  output logic                        wbuf_we_o,
  output logic [wdt_pkg::LenW-1:0]    wbuf_addr_o,
  output logic [7:0]                  wbuf_data_o
);
  logic [wdt_pkg::LenW-1:0]  len_q, len_d;
  logic                      dig_q, dig_d;
  logic [wdt_pkg::SlotW-1:0] tok_q, tok_d;
  logic [7:0] ch;
  logic letter, digit, is_text, is_end, take, word_end;
  wdt_pkg::job_t job;

  always_comb begin
    ch = in_data_i.char_value;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      ch = ch + 8'd32;
    end
  end
  assign letter  = ch >= 8'h61 && ch <= 8'h7a;
  assign digit   = ch >= 8'h30 && ch <= 8'h39;
  assign is_text = in_data_i.operation == wdt_pkg::OpTextByte;
  assign is_end  = in_data_i.operation == wdt_pkg::OpEndText;

  // Word buffer is owned by the back end, so it must be idle before any
  // byte may overwrite the word it still searches.
  assign in_ready_o = job_ready_i && !back_busy_i && !job_valid_o;
  assign take = in_valid_i && in_ready_o;
  assign word_end = is_text && tok_q < wdt_pkg::MaxTok && len_q != '0 &&
                    !((letter || digit) && len_q < wdt_pkg::MaxChars);

  always_comb begin
    job = '0;
    job.has_word  = is_end ? (len_q != '0 && tok_q < wdt_pkg::MaxTok) : word_end;
    job.lookup    = job.has_word && !dig_q;
    job.id        = num_id_i;
    job.len       = len_q;
    job.slot      = tok_q;
    job.pads      = is_end;
    job.last_word = word_end && tok_q == wdt_pkg::MaxTok - 1'b1;
  end

  always_comb begin
    len_d = len_q;
    dig_d = dig_q;
    tok_d = tok_q;
    wbuf_we_o = 1'b0;
    if (take) begin
      if (is_end) begin
        len_d = '0;
        dig_d = 1'b1;
        tok_d = '0;
      end else if (is_text && tok_q < wdt_pkg::MaxTok) begin
        if ((letter || digit) && len_q < wdt_pkg::MaxChars) begin
          wbuf_we_o = 1'b1;
          len_d = len_q + 1'b1;
          if (letter) begin
            dig_d = 1'b0;
          end
        end else if (len_q != '0) begin
          len_d = '0;
          dig_d = 1'b1;
          tok_d = tok_q + 1'b1;
        end
      end
    end
  end
  assign wbuf_addr_o = len_q;
  assign wbuf_data_o = ch;

  logic jv_q;
  wdt_pkg::job_t job_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      dig_q <= 1'b1;
      tok_q <= '0;
      jv_q  <= 1'b0;
    end else begin
      len_q <= len_d;
      dig_q <= dig_d;
      tok_q <= tok_d;
      if (take && (job.has_word || is_end)) begin
        jv_q <= 1'b1;
      end else if (job_ready_i) begin
        jv_q <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job;
    end
  end
  assign job_valid_o = jv_q;
  assign job_o = job_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= wdt_pkg::MaxChars) else $error("word length overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_q <= wdt_pkg::MaxTok) else $error("token count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && is_end |=> tok_q == '0 && len_q == '0) else $error("end not cleared");
endmodule

>>> hdl/wdt_queue.sv
module wdt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wdt_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output wdt_pkg::job_t pop_data_o
);
  wdt_pkg::job_t mem_q [wdt_pkg::QDepth];
  logic [wdt_pkg::QPtrW:0] wp_q, rp_q;

  assign empty_o = wp_q == rp_q;
  assign full_o  = (wp_q[wdt_pkg::QPtrW-1:0] == rp_q[wdt_pkg::QPtrW-1:0]) &&
                   (wp_q[wdt_pkg::QPtrW] != rp_q[wdt_pkg::QPtrW]);
  assign pop_data_o = mem_q[rp_q[wdt_pkg::QPtrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q[wdt_pkg::QPtrW-1:0]] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o)) else $error("queue full and empty");
endmodule

>>> hdl/wdt_back.sv
module wdt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [wdt_pkg::CountW-1:0]  vocab_count_i,
  input  logic                        load_i,
  input  wdt_pkg::in_item_t           load_data_i,
  input  logic                        wbuf_we_i,
  input  logic [wdt_pkg::LenW-1:0]    wbuf_addr_i,
  input  logic [7:0]                  wbuf_data_i,
  input  logic                        job_valid_i,
  input  wdt_pkg::job_t               job_i,
  output logic                        job_pop_o,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wdt_pkg::out_item_t          out_data_o
);
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StLen   = 6'b000010,
    StChar  = 6'b000100,
    StCmp   = 6'b001000,
    StEmit  = 6'b010000,
    StPad   = 6'b100000
  } st_e;

  logic [7:0]  chars_q [wdt_pkg::VocabSize*wdt_pkg::EntryStride];
  logic [4:0]  lens_q  [wdt_pkg::VocabSize];
  logic [15:0] ids_q   [wdt_pkg::VocabSize];
  logic [7:0]  wbuf_q  [wdt_pkg::MaxWordChars];

  st_e st_q, st_d;
  wdt_pkg::job_t job_q;
  logic [wdt_pkg::CountW-1:0] ent_q, ent_d, lim;
  logic [wdt_pkg::PosW-1:0]   pos_q, pos_d;
  logic [wdt_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [wdt_pkg::IdW-1:0]    id_q, id_d;
  logic [4:0]  len_rd_q;
  logic [15:0] id_rd_q;
  logic [7:0]  ch_rd_q, wb_rd_q;
  logic        ov_q;
  wdt_pkg::out_item_t od_q;
  logic        emit, out_free;
  wdt_pkg::out_item_t od;
  // Real count for padding is the first pad slot, saved at pad entry.
  logic [wdt_pkg::SlotW-1:0] real_q;

  assign lim = vocab_count_i > wdt_pkg::VocabLim ? wdt_pkg::VocabLim : vocab_count_i;
  assign out_free = !ov_q || out_ready_i;

  // Vocabulary memories, one write port and one registered read each.
  always_ff @(posedge clk_i) begin
    if (load_i && load_data_i.operation == wdt_pkg::OpLoadChar) begin
      chars_q[{load_data_i.entry_index, load_data_i.char_pos}] <= load_data_i.char_value;
    end
    if (load_i && load_data_i.operation == wdt_pkg::OpLoadEntry) begin
      lens_q[load_data_i.entry_index] <= load_data_i.entry_length;
      ids_q[load_data_i.entry_index]  <= load_data_i.entry_id;
    end
    if (wbuf_we_i) begin
      wbuf_q[wbuf_addr_i] <= wbuf_data_i;
    end
    len_rd_q <= lens_q[ent_d[wdt_pkg::EntryW-1:0]];
    id_rd_q  <= ids_q[ent_d[wdt_pkg::EntryW-1:0]];
    ch_rd_q  <= chars_q[{ent_d[wdt_pkg::EntryW-1:0], pos_d}];
    wb_rd_q  <= wbuf_q[pos_d];
  end

  always_comb begin
    st_d = st_q;
    ent_d = ent_q;
    pos_d = pos_q;
    slot_d = slot_q;
    id_d = id_q;
    job_pop_o = 1'b0;
    emit = 1'b0;
    od = '0;
    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          ent_d = '0;
          pos_d = '0;
          slot_d = job_i.slot;
          id_d = job_i.id;
          if (job_i.lookup) begin
            st_d = StLen;
          end else if (job_i.has_word) begin
            st_d = StEmit;
          end else begin
            st_d = StPad;
          end
        end
      end
      StLen: begin
        // Entry's length and first char read data is now valid.
        if (ent_q >= lim) begin
          id_d = wdt_pkg::UnknownId;
          st_d = StEmit;
        end else begin
          st_d = StCmp;
        end
      end
      StCmp: begin
        if (len_rd_q != job_q.len) begin
          ent_d = ent_q + 1'b1;
          pos_d = '0;
          st_d = StLen;
        end else if (ch_rd_q != wb_rd_q) begin
          ent_d = ent_q + 1'b1;
          pos_d = '0;
          st_d = StLen;
        end else if (wdt_pkg::LenW'(pos_q) + 1'b1 == job_q.len) begin
          id_d = id_rd_q;
          st_d = StEmit;
        end else begin
          pos_d = pos_q + 1'b1;
          st_d = StChar;
        end
      end
      StChar: begin
        st_d = StCmp;
      end
      StEmit: begin
        od.token_id = id_q;
        od.slot = slot_q;
        od.last_flag = job_q.last_word ||
                       (job_q.pads && slot_q == wdt_pkg::MaxTok - 1'b1);
        od.real_count = od.last_flag ? slot_q + 1'b1 : '0;
        if (out_free) begin
          emit = 1'b1;
          slot_d = slot_q + 1'b1;
          st_d = (job_q.pads && slot_q != wdt_pkg::MaxTok - 1'b1) ? StPad : StIdle;
        end
      end
      StPad: begin
        if (slot_q >= wdt_pkg::MaxTok) begin
          st_d = StIdle;
        end else begin
          od.token_id = wdt_pkg::PadToken;
          od.slot = slot_q;
          od.last_flag = slot_q == wdt_pkg::MaxTok - 1'b1;
          od.real_count = od.last_flag ? real_q : '0;
          if (out_free) begin
            emit = 1'b1;
            slot_d = slot_q + 1'b1;
            if (od.last_flag) begin
              st_d = StIdle;
            end
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    pos_q <= pos_d;
    slot_q <= slot_d;
    id_q <= id_d;
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (st_q != StPad && st_d == StPad) begin
      real_q <= slot_d;
    end
    if (emit) begin
      od_q <= od;
    end
  end

  assign busy_o = st_q != StIdle;
  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("output overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StCmp |-> ent_q < lim) else $error("search past vocabulary");
endmodule

>>> hdl/word_dictionary_tokenizer.sv
// Channel   | Dir | Payload
// in_if     | in  | operation, entry_index, char_pos, char_value, entry_id, entry_length
// out_if    | out | token_id, slot, real_count, last_flag
// cfg       | in  | cfg_we_i, cfg_index_i, cfg_data_i
//
// Loads and bytes that extend a word raise no job. A byte that ends a word
// passes a job to the back end; a number needs no search, while a word is
// compared entry by entry and, as the character memory has one read port,
// character by character; it gets the unknown id when nothing matches.
// End of text emits up to 12 results, one per cycle when the sink is ready.
// Reset clears control state only; an output stall holds the back end and
// the input waits while the back end owns the word buffer.
module word_dictionary_tokenizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wdt_in_if.sink                       in_if,
  wdt_out_if.source                    out_if,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [wdt_pkg::CfgW-1:0]     cfg_data_i
);
  logic [wdt_pkg::CountW-1:0] vocab_count_q;
  logic [wdt_pkg::IdW-1:0]    num_id_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_count_q <= '0;
      num_id_q <= wdt_pkg::IdW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wdt_pkg::CfgVocabCount: vocab_count_q <= cfg_data_i[wdt_pkg::CountW-1:0];
        wdt_pkg::CfgNumTokenId: num_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic job_v, job_pop, busy, q_full, q_empty, wb_we, load;
  wdt_pkg::job_t job, qjob;
  logic [wdt_pkg::LenW-1:0] wb_addr;
  logic [7:0] wb_data;

  // Loads go straight to the vocabulary memories at acceptance.
  assign load = in_if.valid && in_if.ready &&
                (in_if.data.operation == wdt_pkg::OpLoadChar ||
                 in_if.data.operation == wdt_pkg::OpLoadEntry);

  wdt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .num_id_i(num_id_q), .back_busy_i(busy || !q_empty),
    .job_valid_o(job_v), .job_o(job), .job_ready_i(!q_full),
    .wbuf_we_o(wb_we), .wbuf_addr_o(wb_addr), .wbuf_data_o(wb_data)
  );

  wdt_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(job_v), .push_data_i(job), .full_o(q_full),
    .pop_i(job_pop), .empty_o(q_empty), .pop_data_o(qjob)
  );

  wdt_back u_back (
    .clk_i, .rst_ni,
    .vocab_count_i(vocab_count_q),
    .load_i(load), .load_data_i(in_if.data),
    .wbuf_we_i(wb_we), .wbuf_addr_i(wb_addr), .wbuf_data_i(wb_data),
    .job_valid_i(!q_empty), .job_i(qjob), .job_pop_o(job_pop), .busy_o(busy),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("output transaction dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !busy) else $error("input taken while back end busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.last_flag |-> out_if.data.real_count <= wdt_pkg::MaxTok)
    else $error("real count out of range");
endmodule
